### rtl/rau_pkg.sv
// rau_pkg: shared types and codes of the rational arithmetic unit
// transaction structs, operation and status codes, sequencer states
// no dependencies
package rau_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } stat_t;

  typedef struct packed {
    logic        [1:0]  action;
    logic signed [31:0] lhs_num;
    logic signed [31:0] lhs_den;
    logic signed [31:0] rhs_num;
    logic signed [31:0] rhs_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_num;
    logic        [30:0] result_den;
    logic        [1:0]  status;
  } out_t;

  // handshake between the engine and the output stage
  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ADDSUB,
    S_PREP,
    S_GCD_SH,
    S_GCD,
    S_GCD_UP,
    S_DIV_NUM,
    S_DIV_DEN,
    S_FIN,
    S_HOLD
  } eng_state_t;

endpackage

### rtl/rau_alu.sv
// rau_alu: the shared adder/subtractor of the engine
// used for shift-add multiply, sum/difference, gcd steps and restoring division
// depends on nothing
module rau_alu #(
  parameter int PW = 64
) (
  input  logic [PW-1:0] a,
  input  logic [PW-1:0] b,
  input  logic          sub,
  output logic [PW-1:0] y,
  output logic          borrow
);
  logic [PW:0] full;

  always_comb begin
    if (sub) begin
      full = {1'b0, a} - {1'b0, b};
    end else begin
      full = {1'b0, a} + {1'b0, b};
    end
  end

  assign y      = full[PW-1:0];
  assign borrow = sub & full[PW];
endmodule

### rtl/rau_engine.sv
// rau_engine: sequencer and datapath registers of the rational arithmetic unit
// products, sum, binary gcd and division by the gcd all run through rau_alu
// depends on rau_pkg and rau_alu
module rau_engine #(
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rau_pkg::in_t      in_data,
  input  logic              take,
  output rau_pkg::eng_stat_t stat,
  output rau_pkg::out_t     res
);
  import rau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * DATA_WIDTH;
  localparam int CW = $clog2(PW);
  localparam logic [PW-1:0] LIM     = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [PW-1:0] LIM_NEG = LIM + 1'b1;

  eng_state_t state_r, state_nxt;
  act_t       act_r, act_nxt;
  logic       rneg_r, rneg_nxt;
  logic       same_r, same_nxt;
  logic [W-1:0] lnm_r, ldm_r, rnm_r, rdm_r;
  logic [W-1:0] lnm_nxt, ldm_nxt, rnm_nxt, rdm_nxt;
  logic [1:0]   mi_r, mi_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [PW-1:0] acc_r, acc_nxt, opa_r, opa_nxt;
  logic [W-1:0]  opb_r, opb_nxt;
  logic [PW-1:0] num_r, num_nxt, den_r, den_nxt, y_r, y_nxt;
  logic [PW-1:0] u_r, u_nxt, v_r, v_nxt;
  logic [PW-1:0] rem_r, rem_nxt, qs_r, qs_nxt;
  out_t          res_r, res_nxt;

  logic [W-1:0] ln_w, ld_w, rn_w, rd_w;
  logic [W-1:0] lnm_c, ldm_c, rnm_c, rdm_c;
  logic [W-1:0] ma, mb;
  logic [PW-1:0] alu_a, alu_b, alu_y, prod, quo;
  logic          alu_sub, alu_borrow;
  logic          addsub, over;
  logic [W-1:0]  mag_w;
  logic signed [W-1:0] num_w;

  rau_alu #(.PW(PW)) u_alu (
    .a      (alu_a),
    .b      (alu_b),
    .sub    (alu_sub),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  // operand magnitudes straight from the input fields
  always_comb begin
    ln_w  = in_data.lhs_num[W-1:0];
    ld_w  = in_data.lhs_den[W-1:0];
    rn_w  = in_data.rhs_num[W-1:0];
    rd_w  = in_data.rhs_den[W-1:0];
    lnm_c = ln_w[W-1] ? (~ln_w + 1'b1) : ln_w;
    ldm_c = ld_w[W-1] ? (~ld_w + 1'b1) : ld_w;
    rnm_c = rn_w[W-1] ? (~rn_w + 1'b1) : rn_w;
    rdm_c = rd_w[W-1] ? (~rd_w + 1'b1) : rd_w;
  end

  assign addsub = (act_r == ACT_ADD) || (act_r == ACT_SUB);

  // factors of each product, picked by product index
  always_comb begin
    ma = ldm_r;
    mb = rdm_r;
    unique case (mi_r)
      2'd0: begin
        ma = lnm_r;
        mb = (act_r == ACT_MUL) ? rnm_r : rdm_r;
      end
      2'd1: begin
        if (addsub) begin
          ma = rnm_r;
          mb = ldm_r;
        end else if (act_r == ACT_MUL) begin
          ma = ldm_r;
          mb = rdm_r;
        end else begin
          ma = ldm_r;
          mb = rnm_r;
        end
      end
      default: begin
        ma = ldm_r;
        mb = rdm_r;
      end
    endcase
  end

  // shared unit input selection
  always_comb begin
    alu_a   = acc_r;
    alu_b   = opa_r;
    alu_sub = 1'b0;
    unique case (state_r)
      S_ADDSUB: begin
        alu_a   = num_r;
        alu_b   = y_r;
        alu_sub = ~same_r;
      end
      S_GCD: begin
        alu_a   = u_r;
        alu_b   = v_r;
        alu_sub = 1'b1;
      end
      S_DIV_NUM, S_DIV_DEN: begin
        alu_a   = {rem_r[PW-2:0], qs_r[PW-1]};
        alu_b   = u_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = acc_r;
        alu_b   = opa_r;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign prod = opb_r[0] ? alu_y : acc_r;
  assign quo  = {qs_r[PW-2:0], ~alu_borrow};

  always_comb begin
    over  = (den_r > LIM) || (rneg_r ? (num_r > LIM_NEG) : (num_r > LIM));
    mag_w = num_r[W-1:0];
    num_w = rneg_r ? (~mag_w + 1'b1) : mag_w;
  end

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    rneg_nxt  = rneg_r;
    same_nxt  = same_r;
    lnm_nxt   = lnm_r;
    ldm_nxt   = ldm_r;
    rnm_nxt   = rnm_r;
    rdm_nxt   = rdm_r;
    mi_nxt    = mi_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    opa_nxt   = opa_r;
    opb_nxt   = opb_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    y_nxt     = y_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    rem_nxt   = rem_r;
    qs_nxt    = qs_r;
    res_nxt   = res_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt  = act_t'(in_data.action);
          lnm_nxt  = lnm_c;
          ldm_nxt  = ldm_c;
          rnm_nxt  = rnm_c;
          rdm_nxt  = rdm_c;
          mi_nxt   = 2'd0;
          // whether both operand fractions have the same sign, the right one negated for a subtract
          same_nxt = ((ln_w[W-1] ^ ld_w[W-1]) ==
                      ((rn_w[W-1] ^ rd_w[W-1]) ^ (in_data.action == ACT_SUB)));
          if ((in_data.action == ACT_ADD) || (in_data.action == ACT_SUB)) begin
            rneg_nxt = ln_w[W-1] ^ ld_w[W-1];
          end else begin
            rneg_nxt = ln_w[W-1] ^ ld_w[W-1] ^ rn_w[W-1] ^ rd_w[W-1];
          end
          res_nxt.result_num = '0;
          res_nxt.result_den = 31'd1;
          if ((ldm_c == '0) || (rdm_c == '0)) begin
            res_nxt.status = ST_INVALID;
            state_nxt      = S_HOLD;
          end else if ((in_data.action == ACT_DIV) && (rnm_c == '0)) begin
            res_nxt.status = ST_DIVZERO;
            state_nxt      = S_HOLD;
          end else begin
            res_nxt.status = ST_OK;
            state_nxt      = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        acc_nxt   = '0;
        opa_nxt   = PW'(ma);
        opb_nxt   = mb;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = prod;
        opa_nxt = {opa_r[PW-2:0], 1'b0};
        opb_nxt = opb_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(W-1)) begin
          unique case (mi_r)
            2'd0:    num_nxt = prod;
            2'd1: begin
              if (addsub) y_nxt = prod;
              else        den_nxt = prod;
            end
            default: den_nxt = prod;
          endcase
          if (addsub ? (mi_r == 2'd2) : (mi_r == 2'd1)) begin
            state_nxt = addsub ? S_ADDSUB : S_PREP;
          end else begin
            mi_nxt    = mi_r + 1'b1;
            state_nxt = S_LOAD;
          end
        end
      end
      S_ADDSUB: begin
        if (same_r || !alu_borrow) begin
          num_nxt   = alu_y;
          state_nxt = S_PREP;
        end else begin
          // smaller minus larger: swap and take the other sign
          num_nxt  = y_r;
          y_nxt    = num_r;
          rneg_nxt = ~rneg_r;
        end
      end
      S_PREP: begin
        if (num_r == '0) begin
          res_nxt.result_num = '0;
          res_nxt.result_den = 31'd1;
          res_nxt.status     = ST_OK;
          state_nxt          = S_HOLD;
        end else begin
          u_nxt     = num_r;
          v_nxt     = den_r;
          k_nxt     = '0;
          state_nxt = S_GCD_SH;
        end
      end
      S_GCD_SH: begin
        if (!u_r[0] && !v_r[0]) begin
          u_nxt = u_r >> 1;
          v_nxt = v_r >> 1;
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        priority if (!u_r[0]) begin
          u_nxt = u_r >> 1;
        end else if (!v_r[0]) begin
          v_nxt = v_r >> 1;
        end else if (alu_borrow) begin
          u_nxt = v_r;
          v_nxt = u_r;
        end else if (alu_y == '0) begin
          state_nxt = S_GCD_UP;
        end else begin
          u_nxt = alu_y >> 1;
        end
      end
      S_GCD_UP: begin
        // restore the common power of two
        if (k_r == '0) begin
          rem_nxt   = '0;
          qs_nxt    = num_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV_NUM;
        end else begin
          u_nxt = {u_r[PW-2:0], 1'b0};
          k_nxt = k_r - 1'b1;
        end
      end
      S_DIV_NUM, S_DIV_DEN: begin
        qs_nxt  = quo;
        rem_nxt = alu_borrow ? alu_a : alu_y;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(PW-1)) begin
          rem_nxt = '0;
          cnt_nxt = '0;
          if (state_r == S_DIV_NUM) begin
            num_nxt   = quo;
            qs_nxt    = den_r;
            state_nxt = S_DIV_DEN;
          end else begin
            den_nxt   = quo;
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (over) begin
          res_nxt.result_num = '0;
          res_nxt.result_den = 31'd1;
          res_nxt.status     = ST_OVERFLOW;
        end else begin
          res_nxt.result_num = 32'(num_w);
          res_nxt.result_den = 31'(den_r[W-2:0]);
          res_nxt.status     = ST_OK;
        end
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r  <= act_nxt;
    rneg_r <= rneg_nxt;
    same_r <= same_nxt;
    lnm_r  <= lnm_nxt;
    ldm_r  <= ldm_nxt;
    rnm_r  <= rnm_nxt;
    rdm_r  <= rdm_nxt;
    mi_r   <= mi_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    opa_r  <= opa_nxt;
    opb_r  <= opb_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    y_r    <= y_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    qs_r   <= qs_nxt;
    res_r  <= res_nxt;
  end

  assign stat.idle = (state_r == S_IDLE);
  assign stat.done = (state_r == S_HOLD);
  assign res       = res_r;
endmodule

### rtl/rational_arithmetic_unit_core.sv
// rational_arithmetic_unit_core: top level, input handshake and output register
// depends on rau_pkg and rau_engine
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | rau_pkg::in_t  (action, two fractions)
//  out_    | output    | out_valid/out_stall | rau_pkg::out_t (reduced fraction, status)
//
// an operand with a zero denominator, or a divide by a zero fraction, goes straight
// to the error result; otherwise the work runs as shift-add products (three for add
// and subtract, two for multiply and divide), a binary gcd and two restoring
// divisions, all on the one shared adder
// in_stall is high from acceptance until the result moves into the output register
// reset clears the sequencer and the output valid; no clearing pass
module rational_arithmetic_unit_core #(
  parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rau_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rau_pkg::out_t out_data
);
  import rau_pkg::*;

  eng_stat_t eng_stat;
  out_t      eng_res;
  out_t      out_r;
  logic      out_valid_r;
  logic      take;

  assign in_stall = ~eng_stat.idle;
  assign take     = eng_stat.done & (~out_valid_r | ~out_stall);

  rau_engine #(.DATA_WIDTH(DATA_WIDTH)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_valid & eng_stat.idle),
    .in_data (in_data),
    .take    (take),
    .stat    (eng_stat),
    .res     (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

### rtl/rau_checker.sv
// rau_checker: port-level assertions for rational_arithmetic_unit_core
// bound to the top level; depends on rau_pkg
module rau_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input rau_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input rau_pkg::out_t out_data
);
  import rau_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  // every error status carries 0/1
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.result_num == 32'sd0) && (out_data.result_den == 31'd1))
    else $error("error status without 0/1 result");

  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_den != 31'd0))
    else $error("zero denominator in result");

  // the engine is busy right after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");
endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### verif/rational_arithmetic_unit_core_checker.sv
// checker for rational_arithmetic_unit_core: watches both channels and predicts results
// compares them against the output; depends on rau_pkg
module rational_arithmetic_unit_core_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  rau_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  rau_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff;

  out_t expected_fractions[$];

  function automatic logic [63:0] gcd_mag(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic logic [63:0] mag_of(logic [31:0] v);
    return v[31] ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
  endfunction

  function automatic out_t predict_fraction(in_t t);
    out_t o;
    act_t op;
    logic an, bn, rn, sy;
    logic [63:0] am, ad, bm, bd, rm, rd, x, y, g;
    op = act_t'(t.action);
    o.result_num = '0;
    o.result_den = 31'd1;
    o.status = ST_OK;
    if (t.lhs_den == 0 || t.rhs_den == 0) begin
      o.status = ST_INVALID;
      return o;
    end
    // normalize each operand: sign to numerator, reduce, zero reads 0/1
    am = mag_of(t.lhs_num);
    ad = mag_of(t.lhs_den);
    an = t.lhs_num[31] ^ t.lhs_den[31];
    if (am == 0) begin
      an = 1'b0;
      ad = 64'd1;
    end else begin
      g = gcd_mag(am, ad);
      am = am / g;
      ad = ad / g;
    end
    bm = mag_of(t.rhs_num);
    bd = mag_of(t.rhs_den);
    bn = t.rhs_num[31] ^ t.rhs_den[31];
    if (bm == 0) begin
      bn = 1'b0;
      bd = 64'd1;
    end else begin
      g = gcd_mag(bm, bd);
      bm = bm / g;
      bd = bd / g;
    end
    if (op == ACT_DIV && bm == 0) begin
      o.status = ST_DIVZERO;
      return o;
    end
    case (op)
      ACT_ADD, ACT_SUB: begin
        x = am * bd;
        y = bm * ad;
        sy = (op == ACT_SUB) ? !bn : bn;
        if (an == sy) begin
          rm = x + y;
          rn = an;
        end else if (x >= y) begin
          rm = x - y;
          rn = an;
        end else begin
          rm = y - x;
          rn = sy;
        end
        rd = ad * bd;
      end
      ACT_MUL: begin
        rm = am * bm;
        rn = an ^ bn;
        rd = ad * bd;
      end
      default: begin
        rm = am * bd;
        rn = an ^ bn;
        rd = ad * bm;
      end
    endcase
    if (rm == 0) begin
      rn = 1'b0;
      rd = 64'd1;
    end else begin
      g = gcd_mag(rm, rd);
      rm = rm / g;
      rd = rd / g;
    end
    if (rd > POS_LIMIT || (rn ? rm > POS_LIMIT + 1 : rm > POS_LIMIT)) begin
      o.status = ST_OVERFLOW;
    end else begin
      o.result_num = rn ? (32'd0 - rm[31:0]) : rm[31:0];
      o.result_den = rd[30:0];
    end
    return o;
  endfunction

  assign pending = expected_fractions.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_fractions.push_back(predict_fraction(in_data));
      if (out_valid && !out_stall) begin
        if (expected_fractions.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction: %p", out_data);
        end else begin
          want = expected_fractions.pop_front();
          if (out_data.result_num !== want.result_num ||
              out_data.result_den !== want.result_den ||
              out_data.status !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected num %0d den %0d status %0d, got num %0d den %0d status %0d",
                       want.result_num, want.result_den, want.status,
                       out_data.result_num, out_data.result_den, out_data.status);
          end
        end
      end
    end
  end
endmodule

### verif/rational_arithmetic_unit_core_test.sv
// testbench top for rational_arithmetic_unit_core: clock, reset, stimulus and verdict
// depends on rau_pkg, the core and rational_arithmetic_unit_core_checker
module rational_arithmetic_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rau_pkg::*;

  localparam int RANDOM_OPS = 1500;
  localparam int CALM_FROM = 1300;
  localparam int STALL_LIMIT = 5000;
  localparam logic [31:0] MIN_INT = 32'h8000_0000;
  localparam logic [31:0] MAX_INT = 32'h7fff_ffff;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fail_count;
  int   pending;
  logic calm;
  int   idle_cycles;

  rational_arithmetic_unit_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rational_arithmetic_unit_core_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // mostly small values so results reduce and fit, with full range and extremes mixed in
  function automatic logic [31:0] pick_value(bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom_range(0, 60) - 30;
      2: v = $urandom_range(0, 2000) - 1000;
      3: v = $urandom;
      4: v = $urandom_range(0, 1) ? MIN_INT : MAX_INT;
      default: v = $urandom_range(0, 1) ? 32'd0 - $urandom_range(1, 3) : $urandom_range(0, 3);
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  function automatic in_t random_op();
    in_t t;
    t.action = 2'($urandom_range(0, 3));
    t.lhs_num = pick_value(0);
    t.rhs_num = pick_value($urandom_range(0, 9) != 0);
    t.lhs_den = pick_value($urandom_range(0, 24) != 0);
    t.rhs_den = pick_value($urandom_range(0, 24) != 0);
    return t;
  endfunction

  function automatic in_t make_op(act_t op, logic [31:0] ln, logic [31:0] ld,
                                  logic [31:0] rn, logic [31:0] rd);
    in_t t;
    t.action = op;
    t.lhs_num = ln;
    t.lhs_den = ld;
    t.rhs_num = rn;
    t.rhs_den = rd;
    return t;
  endfunction

  task automatic send_op(in_t t);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // receiver stalls in bursts until the quiet tail of the run
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(make_op(ACT_ADD, 1, 2, 1, 3));
    send_op(make_op(ACT_SUB, 1, 2, 1, 2));
    send_op(make_op(ACT_MUL, -3, 4, 8, -9));
    send_op(make_op(ACT_DIV, 5, -6, -10, 3));
    send_op(make_op(ACT_ADD, 1, 0, 1, 1));
    send_op(make_op(ACT_MUL, 1, 1, 1, 0));
    send_op(make_op(ACT_DIV, 0, 0, 0, 5));
    send_op(make_op(ACT_DIV, 7, 3, 0, -5));
    send_op(make_op(ACT_DIV, 0, 3, 0, 5));
    send_op(make_op(ACT_ADD, MAX_INT, 1, MAX_INT, 1));
    send_op(make_op(ACT_SUB, MIN_INT, 1, 1, 1));
    send_op(make_op(ACT_ADD, MIN_INT, 1, 0, 1));
    send_op(make_op(ACT_DIV, MIN_INT, -1, 1, 1));
    send_op(make_op(ACT_MUL, MIN_INT, MIN_INT, MAX_INT, MAX_INT));
    send_op(make_op(ACT_MUL, MIN_INT, 1, -1, 1));
    send_op(make_op(ACT_ADD, 1, MAX_INT, 1, MAX_INT - 1));
    send_op(make_op(ACT_DIV, 1, MIN_INT, MAX_INT, 1));
    send_op(make_op(ACT_SUB, -1, MIN_INT, 1, MIN_INT));
    send_op(make_op(ACT_MUL, 0, MIN_INT, MAX_INT, -1));
    send_op(make_op(ACT_ADD, 6, 4, -3, -2));

    // hold off until the block has drained
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      send_op(random_op());
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### files.f
rtl/rau_pkg.sv
rtl/rau_alu.sv
rtl/rau_engine.sv
rtl/rational_arithmetic_unit_core.sv
rtl/rau_checker.sv
verif/rational_arithmetic_unit_core_checker.sv
verif/rational_arithmetic_unit_core_test.sv
